@@ sv/mnrm_pkg.sv @@
// Shared constants, codes and control/status types of the note router and mixer.
`timescale 1ns / 1ps
`default_nettype none
package mnrm_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int PORT_COUNT = 8;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [6:0] DEFAULT_VELOCITY = 7'd100;
    localparam logic [6:0] NOTE_LIMIT = 7'd127;
    localparam logic [6:0] VEL_LIMIT = 7'd127;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_NOTE_ON = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    localparam logic [2:0] CFG_MASTER_VOLUME = 3'd0;
    localparam logic [2:0] CFG_MASTER_MIN_NOTE = 3'd1;
    localparam logic [2:0] CFG_MASTER_MAX_NOTE = 3'd2;
    localparam logic [2:0] CFG_MASTER_TRANSPOSE = 3'd3;
    localparam logic [2:0] CFG_MASTER_PAN = 3'd4;

    typedef struct packed {
        logic              write_slot;
        logic              load_note;
        logic              issue;
        logic [SLOT_W-1:0] idx;
        logic              flush;
    } t_cmd;

    typedef struct packed {
        logic hold;
        logic pipe_empty;
        logic flush_ok;
    } t_status;

endpackage
`default_nettype wire

@@ sv/mnrm_ctrl.sv @@
// Controller: accepts words and sequences the slot walk, drain and final flush.
`timescale 1ns / 1ps
`default_nettype none
module mnrm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [1:0]        i_operation,
    output logic                   o_stall,
    output mnrm_pkg::t_cmd         o_cmd,
    input  wire mnrm_pkg::t_status i_status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [mnrm_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic w_accept;
    logic w_is_note;
    logic w_last_idx;

    assign o_stall = (r_state != ST_IDLE) || !i_rst_n;
    assign w_accept = i_valid && !o_stall;
    assign w_is_note = (i_operation == mnrm_pkg::OP_NOTE_ON) ||
                       (i_operation == mnrm_pkg::OP_NOTE_OFF);
    assign w_last_idx = (r_idx == mnrm_pkg::SLOT_W'(mnrm_pkg::SLOT_COUNT - 1));

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_is_note) begin
                    n_state = ST_WALK;
                    n_idx = '0;
                end
            end
            ST_WALK: begin
                if (!i_status.hold) begin
                    if (w_last_idx) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_status.flush_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

    always_comb begin
        o_cmd.write_slot = w_accept && (i_operation == mnrm_pkg::OP_WRITE);
        o_cmd.load_note = w_accept && w_is_note;
        o_cmd.issue = (r_state == ST_WALK);
        o_cmd.idx = r_idx;
        o_cmd.flush = (r_state == ST_FLUSH);
    end

    a_walk_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) && !$past(r_state == ST_WALK) |-> r_idx == '0)
        else $error("walk did not start at slot zero");

    a_flush_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) && (($past(r_state) == ST_DRAIN)) |-> i_status.pipe_empty)
        else $error("flush entered with words still in the pipeline");

    a_stall_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall && !o_cmd.load_note && !o_cmd.write_slot)
        else $error("word accepted while busy");

endmodule
`default_nettype wire

@@ sv/mnrm_dp.sv @@
// Datapath: routing table, master registers, slot evaluation pipeline and output register.
`timescale 1ns / 1ps
`default_nettype none
module mnrm_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mnrm_pkg::t_cmd      i_cmd,
    output mnrm_pkg::t_status        o_status,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [11:0]         i_cfg_data,
    input  wire logic [1:0]          i_operation,
    input  wire logic [3:0]          i_slot,
    input  wire logic [7:0]          i_track_id,
    input  wire logic                i_slot_valid,
    input  wire logic [3:0]          i_port,
    input  wire logic [3:0]          i_midi_channel,
    input  wire logic signed [7:0]   i_slot_transpose,
    input  wire logic [11:0]         i_slot_volume,
    input  wire logic signed [7:0]   i_slot_pan,
    input  wire logic [6:0]          i_note_number,
    input  wire logic [6:0]          i_note_velocity,
    input  wire logic                i_velocity_given,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [3:0]               o_out_port,
    output logic [3:0]               o_out_channel,
    output logic [7:0]               o_out_track,
    output logic [6:0]               o_out_note,
    output logic [6:0]               o_out_velocity,
    output logic signed [7:0]        o_out_pan,
    output logic                     o_out_on,
    output logic                     o_last_of_run
);

    localparam int SC = mnrm_pkg::SLOT_COUNT;

    // master registers
    logic [11:0]       r_mvol;
    logic [6:0]        r_min;
    logic [6:0]        r_max;
    logic signed [7:0] r_mtrans;
    logic signed [7:0] r_mpan;

    // routing table
    logic [SC-1:0]     r_tbl_valid;
    logic [7:0]        r_tbl_track [SC];
    logic [3:0]        r_tbl_port [SC];
    logic [3:0]        r_tbl_chan [SC];
    logic signed [7:0] r_tbl_trans [SC];
    logic [11:0]       r_tbl_vol [SC];
    logic signed [7:0] r_tbl_pan [SC];

    // current note word
    logic        r_on;
    logic [7:0]  r_track;
    logic [6:0]  r_note;
    logic [6:0]  r_vel;

    // stage 1
    logic              r_s1_vld;
    logic [3:0]        r_s1_port;
    logic [3:0]        r_s1_chan;
    logic [6:0]        r_s1_note;
    logic signed [7:0] r_s1_pan;
    logic [18:0]       r_s1_prod;

    // stage 2
    logic              r_s2_vld;
    logic [3:0]        r_s2_port;
    logic [3:0]        r_s2_chan;
    logic [6:0]        r_s2_note;
    logic signed [7:0] r_s2_pan;
    logic [30:0]       r_s2_prod;

    // pending message
    logic              r_pend_vld;
    logic [3:0]        r_pend_port;
    logic [3:0]        r_pend_chan;
    logic [6:0]        r_pend_note;
    logic [6:0]        r_pend_vel;
    logic signed [7:0] r_pend_pan;

    // output register
    logic              r_out_vld;
    logic [3:0]        r_out_port;
    logic [3:0]        r_out_chan;
    logic [7:0]        r_out_track;
    logic [6:0]        r_out_note;
    logic [6:0]        r_out_vel;
    logic signed [7:0] r_out_pan;
    logic              r_out_on;
    logic              r_out_last;

    logic [mnrm_pkg::SLOT_W-1:0] w_wr_idx;
    logic              w_wr_ok;
    logic [3:0]        w_port_clamp;
    logic signed [9:0] w_n;
    logic              w_in_range;
    logic              w_match;
    logic signed [8:0] w_pan_sum;
    logic signed [7:0] w_pan_sat;
    logic [18:0]       w_prod1;
    logic [30:0]       w_prod2;
    logic [14:0]       w_vel_raw;
    logic [6:0]        w_vel_clamp;
    logic              w_keep2;
    logic              w_out_take;
    logic              w_out_free;
    logic              w_hold;
    logic              w_adv;
    logic              w_push_pend;
    logic              w_flush_out;
    logic              w_load_out;

    assign w_wr_idx = mnrm_pkg::SLOT_W'(i_slot);
    assign w_wr_ok = ({1'b0, i_slot} < 5'(SC)) || (SC > 15);
    assign w_port_clamp = (i_port > 4'(mnrm_pkg::PORT_COUNT)) ?
                          4'(mnrm_pkg::PORT_COUNT) : i_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvol <= 12'd256;
            r_min <= 7'd0;
            r_max <= mnrm_pkg::NOTE_LIMIT;
            r_mtrans <= '0;
            r_mpan <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mnrm_pkg::CFG_MASTER_VOLUME:    r_mvol <= i_cfg_data;
                mnrm_pkg::CFG_MASTER_MIN_NOTE:  r_min <= i_cfg_data[6:0];
                mnrm_pkg::CFG_MASTER_MAX_NOTE:  r_max <= i_cfg_data[6:0];
                mnrm_pkg::CFG_MASTER_TRANSPOSE: r_mtrans <= $signed(i_cfg_data[7:0]);
                mnrm_pkg::CFG_MASTER_PAN:       r_mpan <= $signed(i_cfg_data[7:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_valid <= '0;
        end else if (i_cmd.write_slot && w_wr_ok) begin
            r_tbl_valid[w_wr_idx] <= i_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_slot && w_wr_ok) begin
            r_tbl_track[w_wr_idx] <= i_track_id;
            r_tbl_port[w_wr_idx] <= w_port_clamp;
            r_tbl_chan[w_wr_idx] <= i_midi_channel;
            r_tbl_trans[w_wr_idx] <= i_slot_transpose;
            r_tbl_vol[w_wr_idx] <= i_slot_volume;
            r_tbl_pan[w_wr_idx] <= i_slot_pan;
        end
        if (i_cmd.load_note) begin
            r_on <= (i_operation == mnrm_pkg::OP_NOTE_ON);
            r_track <= i_track_id;
            r_note <= i_note_number;
            r_vel <= i_velocity_given ? i_note_velocity : mnrm_pkg::DEFAULT_VELOCITY;
        end
    end

    // slot evaluation
    assign w_n = $signed({3'b000, r_note}) + 10'(r_tbl_trans[i_cmd.idx]) + 10'(r_mtrans);
    assign w_in_range = (w_n >= 10'sd0) && (w_n <= $signed({3'b000, mnrm_pkg::NOTE_LIMIT})) &&
                        (w_n >= $signed({3'b000, r_min})) && (w_n <= $signed({3'b000, r_max}));
    assign w_match = r_tbl_valid[i_cmd.idx] && (r_tbl_track[i_cmd.idx] == r_track);
    assign w_pan_sum = 9'(r_tbl_pan[i_cmd.idx]) + 9'(r_mpan);
    assign w_pan_sat = (w_pan_sum > 9'sd127) ? 8'sd127 :
                       (w_pan_sum < -9'sd128) ? $signed(8'h80) : w_pan_sum[7:0];
    assign w_prod1 = {12'd0, r_vel} * {7'd0, r_tbl_vol[i_cmd.idx]};
    assign w_prod2 = {12'd0, r_s1_prod} * {19'd0, r_mvol};

    assign w_vel_raw = r_s2_prod[30:16];
    assign w_vel_clamp = (w_vel_raw > {8'd0, mnrm_pkg::VEL_LIMIT}) ?
                         mnrm_pkg::VEL_LIMIT : w_vel_raw[6:0];
    assign w_keep2 = r_s2_vld && (!r_on || (w_vel_raw != 15'd0));

    assign w_out_take = r_out_vld && !i_stall;
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_hold = w_keep2 && r_pend_vld && !w_out_free;
    assign w_adv = !w_hold;
    assign w_push_pend = w_adv && w_keep2;
    assign w_flush_out = i_cmd.flush && r_pend_vld && w_out_free;
    assign w_load_out = (w_push_pend && r_pend_vld) || w_flush_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_vld <= i_cmd.issue && w_match && w_in_range;
                r_s2_vld <= r_s1_vld;
            end
            if (w_push_pend) begin
                r_pend_vld <= 1'b1;
            end else if (w_flush_out) begin
                r_pend_vld <= 1'b0;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (w_out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_port <= r_tbl_port[i_cmd.idx];
            r_s1_chan <= r_tbl_chan[i_cmd.idx];
            r_s1_note <= w_n[6:0];
            r_s1_pan <= w_pan_sat;
            r_s1_prod <= w_prod1;
            r_s2_port <= r_s1_port;
            r_s2_chan <= r_s1_chan;
            r_s2_note <= r_s1_note;
            r_s2_pan <= r_s1_pan;
            r_s2_prod <= w_prod2;
        end
        if (w_push_pend) begin
            r_pend_port <= r_s2_port;
            r_pend_chan <= r_s2_chan;
            r_pend_note <= r_s2_note;
            r_pend_vel <= r_on ? w_vel_clamp : 7'd0;
            r_pend_pan <= r_s2_pan;
        end
        if (w_load_out) begin
            r_out_port <= r_pend_port;
            r_out_chan <= r_pend_chan;
            r_out_track <= r_track;
            r_out_note <= r_pend_note;
            r_out_vel <= r_pend_vel;
            r_out_pan <= r_pend_pan;
            r_out_on <= r_on;
            r_out_last <= w_flush_out;
        end
    end

    always_comb begin
        o_status.hold = w_hold;
        o_status.pipe_empty = !r_s1_vld && !r_s2_vld;
        o_status.flush_ok = !r_pend_vld || w_out_free;
    end

    assign o_valid = r_out_vld;
    assign o_out_port = r_out_port;
    assign o_out_channel = r_out_chan;
    assign o_out_track = r_out_track;
    assign o_out_note = r_out_note;
    assign o_out_velocity = r_out_vel;
    assign o_out_pan = r_out_pan;
    assign o_out_on = r_out_on;
    assign o_last_of_run = r_out_last;

    a_flush_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> !r_s1_vld && !r_s2_vld)
        else $error("flush with slots still in flight");

    a_note_starts_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_note |-> !r_pend_vld && !r_s1_vld && !r_s2_vld)
        else $error("note word accepted over unfinished work");

    a_on_nonzero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_on |-> r_out_vel != 7'd0)
        else $error("note-on word with zero velocity");

    a_off_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_on |-> r_out_vel == 7'd0)
        else $error("note-off word with nonzero velocity");

endmodule
`default_nettype wire

@@ sv/midi_note_route_mixer_top.sv @@
// Top level of the note router and mixer: controller plus datapath.
// A write word loads one routing slot and does not stall the input. A note word walks all
// SLOT_COUNT slots, one slot per cycle while the pipeline is not held, through a three-stage
// evaluation pipeline (table read and first gain multiply, second gain multiply, clamp and
// select), so after it is taken the input stalls through the walk, the drain of the pipeline
// and the flush of the last message, and also while the output is stalled and a message
// waits to move on.
// Each routed message is held one slot back so that the final one of a note carries
// last_of_run; a note that routes nowhere produces no word. The next word is accepted while
// the last message still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module midi_note_route_mixer_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [11:0]       i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [3:0]        i_slot,
    input  wire logic [7:0]        i_track_id,
    input  wire logic              i_slot_valid,
    input  wire logic [3:0]        i_port,
    input  wire logic [3:0]        i_midi_channel,
    input  wire logic signed [7:0] i_slot_transpose,
    input  wire logic [11:0]       i_slot_volume,
    input  wire logic signed [7:0] i_slot_pan,
    input  wire logic [6:0]        i_note_number,
    input  wire logic [6:0]        i_note_velocity,
    input  wire logic              i_velocity_given,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [3:0]             o_out_port,
    output logic [3:0]             o_out_channel,
    output logic [7:0]             o_out_track,
    output logic [6:0]             o_out_note,
    output logic [6:0]             o_out_velocity,
    output logic signed [7:0]      o_out_pan,
    output logic                   o_out_on,
    output logic                   o_last_of_run
);

    mnrm_pkg::t_cmd    w_cmd;
    mnrm_pkg::t_status w_status;

    mnrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    mnrm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_slot           (i_slot),
        .i_track_id       (i_track_id),
        .i_slot_valid     (i_slot_valid),
        .i_port           (i_port),
        .i_midi_channel   (i_midi_channel),
        .i_slot_transpose (i_slot_transpose),
        .i_slot_volume    (i_slot_volume),
        .i_slot_pan       (i_slot_pan),
        .i_note_number    (i_note_number),
        .i_note_velocity  (i_note_velocity),
        .i_velocity_given (i_velocity_given),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_port       (o_out_port),
        .o_out_channel    (o_out_channel),
        .o_out_track      (o_out_track),
        .o_out_note       (o_out_note),
        .o_out_velocity   (o_out_velocity),
        .o_out_pan        (o_out_pan),
        .o_out_on         (o_out_on),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
`default_nettype wire
